FILE: rtl/hermitian_6x6_complex_matvec_core_macros.svh
// Assertion macros for the packed Hermitian 6x6 matrix-vector core.
// Used by the core RTL files; depends on nothing.
`ifndef HERMITIAN_6X6_COMPLEX_MATVEC_CORE_MACROS_SVH
`define HERMITIAN_6X6_COMPLEX_MATVEC_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HX6_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("hx6 assertion failed");
`define HX6_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("hx6 forbidden condition");
`else
`define HX6_ASSERT(lbl, clk, rst, prop)
`define HX6_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: rtl/hx6_pkg.sv
// Shared types and constants of the packed Hermitian 6x6 matrix-vector core.
// Depends on nothing.
`timescale 1ns / 1ps
package hx6_pkg;

   localparam int DATA_W      = 32;
   localparam int MAT_WORDS   = 36;
   localparam int VEC_WORDS   = 12;
   localparam int BLOCK_WORDS = 48;
   localparam int POS_W       = 6;
   localparam int MAT_AW      = 6;
   localparam int VEC_AW      = 4;
   localparam int COMP_W      = 4;
   localparam int IDX_W       = 3;
   localparam int ACC_W       = 70;
   localparam int PROD_W      = 2 * DATA_W;

   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(BLOCK_WORDS - 1);
   localparam logic [POS_W-1:0]  MAT_END   = POS_W'(MAT_WORDS);
   localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(5);
   localparam logic [COMP_W-1:0] COMP_LAST = COMP_W'(VEC_WORDS - 1);

   // product selection within one matrix entry times one vector element
   typedef enum logic [1:0] {
      STEP_RR,
      STEP_II,
      STEP_RI,
      STEP_IR
   } step_type;

   typedef struct packed {
      logic valid;
      logic to_im;
      logic subtract;
      logic zero;
   } mac_ctl_type;

   // start of row r in the packed matrix: r*r
   function automatic logic [MAT_AW-1:0] row_base(input logic [IDX_W-1:0] r);
      logic [MAT_AW-1:0] base;
      case (r)
         3'd0: base = 6'd0;
         3'd1: base = 6'd1;
         3'd2: base = 6'd4;
         3'd3: base = 6'd9;
         3'd4: base = 6'd16;
         3'd5: base = 6'd25;
         default: base = 6'd0;
      endcase
      return base;
   endfunction

endpackage

FILE: rtl/hx6_if.sv
// Request and response channel interfaces of the Hermitian matvec core.
// Depends on hx6_pkg.
`timescale 1ns / 1ps
interface hx6_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [hx6_pkg::DATA_W-1:0] word;
   logic                              first_word;

   modport source (output valid, output word, output first_word, input ready);
   modport sink   (input valid, input word, input first_word, output ready);
endinterface

interface hx6_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [hx6_pkg::DATA_W-1:0] product_word;
   logic [hx6_pkg::COMP_W-1:0]        component;
   logic                              last_of_block;

   modport source (output valid, output product_word, output component,
                   output last_of_block, input ready);
   modport sink   (input valid, input product_word, input component,
                   input last_of_block, output ready);
endinterface

FILE: rtl/hx6_store.sv
// Matrix and vector word memories, one write port and registered reads.
// Depends on hx6_pkg.
`timescale 1ns / 1ps
module hx6_store (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [hx6_pkg::POS_W-1:0]         wr_addr,
   input  logic signed [hx6_pkg::DATA_W-1:0] wr_data,
   input  logic [hx6_pkg::MAT_AW-1:0]        mat_rd_addr,
   input  logic [hx6_pkg::VEC_AW-1:0]        vec_rd_addr,
   output logic signed [hx6_pkg::DATA_W-1:0] mat_rd_data,
   output logic signed [hx6_pkg::DATA_W-1:0] vec_rd_data
);

   logic signed [hx6_pkg::DATA_W-1:0] mat_mem_ff [hx6_pkg::MAT_WORDS];
   logic signed [hx6_pkg::DATA_W-1:0] vec_mem_ff [hx6_pkg::VEC_WORDS];
   logic signed [hx6_pkg::DATA_W-1:0] mat_rd_ff;
   logic signed [hx6_pkg::DATA_W-1:0] vec_rd_ff;
   logic [hx6_pkg::VEC_AW-1:0]        vec_off;
   logic                              is_mat;

   assign is_mat  = (wr_addr < hx6_pkg::MAT_END);
   assign vec_off = hx6_pkg::VEC_AW'(wr_addr - hx6_pkg::MAT_END);

   always_ff @(posedge clock) begin
      if (wr_en && is_mat) begin
         mat_mem_ff[wr_addr] <= wr_data;
      end
      mat_rd_ff <= mat_mem_ff[mat_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en && !is_mat) begin
         vec_mem_ff[vec_off] <= wr_data;
      end
      vec_rd_ff <= vec_mem_ff[vec_rd_addr];
   end

   assign mat_rd_data = mat_rd_ff;
   assign vec_rd_data = vec_rd_ff;

endmodule

FILE: rtl/hx6_mac.sv
// Shared signed multiply-accumulate unit with real and imaginary sums,
// plus the shift and saturation of both sums. Depends on hx6_pkg and macros.
`timescale 1ns / 1ps
`include "hermitian_6x6_complex_matvec_core_macros.svh"
module hx6_mac #(
   parameter int FRAC_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hx6_pkg::mac_ctl_type              issue,
   input  logic                              acc_clear,
   input  logic signed [hx6_pkg::DATA_W-1:0] mat_data,
   input  logic signed [hx6_pkg::DATA_W-1:0] vec_data,
   output logic signed [hx6_pkg::DATA_W-1:0] re_sat,
   output logic signed [hx6_pkg::DATA_W-1:0] im_sat
);

   localparam int HI_W = hx6_pkg::ACC_W - hx6_pkg::DATA_W + 1;

   hx6_pkg::mac_ctl_type              s1_ff, s2_ff;
   logic signed [hx6_pkg::DATA_W-1:0] op_a;
   logic signed [hx6_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic signed [hx6_pkg::ACC_W-1:0]  addend;
   logic signed [hx6_pkg::ACC_W-1:0]  acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic signed [hx6_pkg::ACC_W-1:0]  re_shift, im_shift;

   assign op_a    = s1_ff.zero ? '0 : mat_data;
   assign prod_in = op_a * vec_data;
   assign addend  = {{(hx6_pkg::ACC_W - hx6_pkg::PROD_W){prod_ff[hx6_pkg::PROD_W-1]}},
                     prod_ff};

   always_comb begin
      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      if (acc_clear) begin
         acc_re_in = '0;
         acc_im_in = '0;
      end else if (s2_ff.valid) begin
         if (s2_ff.to_im) begin
            acc_im_in = s2_ff.subtract ? acc_im_ff - addend : acc_im_ff + addend;
         end else begin
            acc_re_in = s2_ff.subtract ? acc_re_ff - addend : acc_re_ff + addend;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
      end else begin
         s1_ff <= issue;
         s2_ff <= s1_ff;
      end
      prod_ff   <= prod_in;
      acc_re_ff <= acc_re_in;
      acc_im_ff <= acc_im_in;
   end

   function automatic logic signed [hx6_pkg::DATA_W-1:0] sat(
      input logic signed [hx6_pkg::ACC_W-1:0] v
   );
      logic [HI_W-1:0] hi;
      logic signed [hx6_pkg::DATA_W-1:0] r;
      hi = v[hx6_pkg::ACC_W-1:hx6_pkg::DATA_W-1];
      if ((&hi) || !(|hi)) begin
         r = v[hx6_pkg::DATA_W-1:0];
      end else if (hi[HI_W-1]) begin
         r = {1'b1, {(hx6_pkg::DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(hx6_pkg::DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   assign re_shift = acc_re_ff >>> FRAC_BITS;
   assign im_shift = acc_im_ff >>> FRAC_BITS;
   assign re_sat   = sat(re_shift);
   assign im_sat   = sat(im_shift);

   `HX6_ASSERT(a_clear_idle, clock, reset, acc_clear |-> !s1_ff.valid && !s2_ff.valid)

endmodule

FILE: rtl/hermitian_6x6_complex_matvec_core.sv
// Packed Hermitian 6x6 complex matrix times complex vector, signed Q7.24.
//
// req_if takes one 32-bit word per request: 36 packed matrix words, then
// 12 vector words (re, im pairs). first_word forces the word to position 0
// and drops any partial block. Loading runs at one request per cycle.
// After the 48th word the core stops taking requests and runs 144
// multiply-accumulates through one 32x32 multiplier: 24 per output row,
// one per cycle, then a pipeline drain (memory read, multiply,
// accumulate). Each row then shows its real and imaginary result on
// rsp_if, one response each, from an output register.
// The core holds each response until it is taken, and it takes no new
// block until the last response of the block has been taken.
// Reset (synchronous, active high) returns to position 0 with no response
// pending; store contents are left as they are.
// Depends on hx6_pkg, hx6_if, hx6_store, hx6_mac and the macro header.
`timescale 1ns / 1ps
`include "hermitian_6x6_complex_matvec_core_macros.svh"
module hermitian_6x6_complex_matvec_core #(
   parameter int FRAC_BITS = 24
) (
   input logic       clock,
   input logic       reset,
   hx6_req_if.sink   req_if,
   hx6_rsp_if.source rsp_if
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_SEND_RE,
      ST_SEND_IM
   } state_type;

   state_type                         state_ff, state_in;
   logic [hx6_pkg::POS_W-1:0]         pos_ff, pos_in, pos_sel;
   logic [hx6_pkg::IDX_W-1:0]         row_ff, row_in, col_ff, col_in;
   hx6_pkg::step_type                 step_ff, step_in;
   logic [1:0]                        drain_ff, drain_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [hx6_pkg::DATA_W-1:0] rsp_word_ff, rsp_word_in;
   logic [hx6_pkg::COMP_W-1:0]        rsp_comp_ff, rsp_comp_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              req_acc, rsp_acc;
   logic                              lower, upper, diag, im_sel, x_im;
   logic [hx6_pkg::MAT_AW-1:0]        mat_addr;
   logic [hx6_pkg::VEC_AW-1:0]        vec_addr;
   logic signed [hx6_pkg::DATA_W-1:0] mat_data, vec_data, re_sat, im_sat;
   hx6_pkg::mac_ctl_type              issue;
   logic                              acc_clear;

   assign req_if.ready         = (state_ff == ST_LOAD);
   assign req_acc              = req_if.valid && req_if.ready;
   assign rsp_acc              = rsp_if.valid && rsp_if.ready;
   assign pos_sel              = req_if.first_word ? '0 : pos_ff;
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.product_word  = rsp_word_ff;
   assign rsp_if.component     = rsp_comp_ff;
   assign rsp_if.last_of_block = rsp_last_ff;

   // address the packed entry and the vector element of this product
   assign lower  = (col_ff < row_ff);
   assign upper  = (col_ff > row_ff);
   assign diag   = (col_ff == row_ff);
   assign im_sel = ((step_ff == hx6_pkg::STEP_II) || (step_ff == hx6_pkg::STEP_IR)) && !diag;
   assign x_im   = (step_ff == hx6_pkg::STEP_II) || (step_ff == hx6_pkg::STEP_RI);

   always_comb begin
      if (upper) begin
         mat_addr = hx6_pkg::row_base(col_ff) + {2'b00, row_ff, 1'b0};
      end else begin
         mat_addr = hx6_pkg::row_base(row_ff) + {2'b00, col_ff, 1'b0};
      end
      mat_addr = mat_addr + {5'd0, im_sel};
   end

   assign vec_addr = {col_ff, x_im};

   assign issue.valid    = (state_ff == ST_ISSUE);
   assign issue.to_im    = (step_ff == hx6_pkg::STEP_RI) || (step_ff == hx6_pkg::STEP_IR);
   assign issue.subtract = ((step_ff == hx6_pkg::STEP_II) && lower) ||
                           ((step_ff == hx6_pkg::STEP_IR) && upper);
   assign issue.zero     = diag && ((step_ff == hx6_pkg::STEP_II) ||
                                    (step_ff == hx6_pkg::STEP_IR));
   assign acc_clear      = issue.valid && (col_ff == '0) && (step_ff == hx6_pkg::STEP_RR);

   hx6_store u_store (
      .clock       (clock),
      .wr_en       (req_acc),
      .wr_addr     (pos_sel),
      .wr_data     (req_if.word),
      .mat_rd_addr (mat_addr),
      .vec_rd_addr (vec_addr),
      .mat_rd_data (mat_data),
      .vec_rd_data (vec_data)
   );

   hx6_mac #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .issue     (issue),
      .acc_clear (acc_clear),
      .mat_data  (mat_data),
      .vec_data  (vec_data),
      .re_sat    (re_sat),
      .im_sat    (im_sat)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      step_in      = step_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (pos_sel == hx6_pkg::LAST_POS) begin
                  pos_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  step_in  = hx6_pkg::STEP_RR;
                  state_in = ST_ISSUE;
               end else begin
                  pos_in = pos_sel + 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            step_in = hx6_pkg::step_type'(step_ff + 2'd1);
            if (step_ff == hx6_pkg::STEP_IR) begin
               if (col_ff == hx6_pkg::LAST_IDX) begin
                  col_in   = '0;
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd2) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = re_sat;
               rsp_comp_in  = {row_ff, 1'b0};
               rsp_last_in  = 1'b0;
               state_in     = ST_SEND_RE;
            end
         end
         ST_SEND_RE: begin
            if (rsp_acc) begin
               rsp_word_in = im_sat;
               rsp_comp_in = {row_ff, 1'b1};
               rsp_last_in = (row_ff == hx6_pkg::LAST_IDX);
               state_in    = ST_SEND_IM;
            end
         end
         ST_SEND_IM: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (row_ff == hx6_pkg::LAST_IDX) begin
                  row_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  row_in   = row_ff + 1'b1;
                  step_in  = hx6_pkg::STEP_RR;
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         step_ff      <= hx6_pkg::STEP_RR;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         step_ff      <= step_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      rsp_comp_ff <= rsp_comp_in;
      rsp_last_ff <= rsp_last_in;
   end

   `HX6_NEVER(a_no_overlap, clock, reset, req_if.ready && rsp_if.valid)
   `HX6_ASSERT(a_last_comp, clock, reset, rsp_if.valid && rsp_if.last_of_block |-> rsp_if.component == hx6_pkg::COMP_LAST)
   `HX6_ASSERT(a_block_end, clock, reset, req_acc && pos_sel == hx6_pkg::LAST_POS |=> !req_if.ready)
   `HX6_ASSERT(a_reload, clock, reset, rsp_acc && rsp_if.last_of_block |=> req_if.ready)

endmodule
